@@ rtl/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with k-th-from-end lookup.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int REQ_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_KTH_BACK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] value_in;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } cmd_t;

endpackage

@@ rtl/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: latch a request, execute it against the ring, emit the result.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.emit = (state_reg == S_RESP);

endmodule

@@ rtl/bdq_datapath.sv @@
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, front pointer, count and direction flag with request decode.
// ----------------------------------------------------------------------------
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req,
    output rsp_t rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    localparam logic [IW-1:0] LAST_SLOT  = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_WIDE = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);

    logic signed [DATA_W-1:0] mem [DEPTH];

    req_t               req_reg;
    logic [IW-1:0]      front_reg;
    logic [IW-1:0]      front_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               rev_reg;
    logic               rev_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic               hit_reg;
    logic               hit_next;
    logic [DATA_W-1:0]  rdata_reg;

    logic               empty;
    logic               full;
    logic [MW-1:0]      count_ext;
    logic [MW-1:0]      pos_ext;
    logic [MW-1:0]      off_wide;
    logic [IW-1:0]      off;
    logic [IW:0]        slot_sum;
    logic [IW-1:0]      slot;
    logic [IW-1:0]      front_dec;
    logic [IW-1:0]      front_inc;
    logic               at_end;
    logic               take_start;
    logic               mem_we;
    logic               mem_re;
    logic [IW-1:0]      mem_addr;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == DEPTH_CNT);
    assign count_ext = MW'(count_reg);
    assign pos_ext   = MW'(req_reg.position);

    assign at_end     = (req_reg.req_type == REQ_PUSH_BACK) != rev_reg;
    assign take_start = (req_reg.req_type == REQ_POP_FRONT) != rev_reg;

    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;

    // offset from the physical first entry for the slot this request touches
    always_comb
    begin
        off_wide = '0;
        unique case (req_reg.req_type)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: off_wide = count_ext;
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                off_wide = take_start ? '0 : count_ext - 1'b1;
            end
            REQ_KTH_BACK:
            begin
                off_wide = rev_reg ? pos_ext - 1'b1 : count_ext - pos_ext;
            end
            default: off_wide = '0;
        endcase
    end

    // offset stays below DEPTH, so one conditional subtract wraps the slot
    assign off      = off_wide[IW-1:0];
    assign slot_sum = {1'b0, front_reg} + {1'b0, off};
    assign slot     = (slot_sum >= DEPTH_WIDE) ? IW'(slot_sum - DEPTH_WIDE)
                                               : slot_sum[IW-1:0];

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = STAT_OK;
        hit_next    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = slot;
        unique case (req_reg.req_type)
            REQ_PUSH_BACK, REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (!at_end)
                    begin
                        mem_addr   = front_dec;
                        front_next = front_dec;
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    mem_re     = 1'b1;
                    hit_next   = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (take_start)
                    begin
                        front_next = front_inc;
                    end
                end
            end
            REQ_KTH_BACK:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (pos_ext == '0 || pos_ext > count_ext)
                begin
                    status_next = STAT_RANGE;
                end
                else
                begin
                    mem_re   = 1'b1;
                    hit_next = 1'b1;
                end
            end
            REQ_REVERSE: rev_next = !rev_reg;
            default:     status_next = STAT_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec && mem_we)
        begin
            mem[mem_addr] <= req_reg.value_in;
        end
        if (cmd.exec && mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            status_reg <= STAT_OK;
            hit_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    // value_out is the read data while emit is high after a read; otherwise it is zero
    assign rsp.value_out = (cmd.emit && hit_reg) ? rdata_reg : '0;
    assign rsp.status    = status_reg;
    assign rsp.occupancy = count_ext[OCC_W-1:0];

endmodule

@@ rtl/bounded_deque_with_kth_from_end.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_kth_from_end
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   Result channel: done is high for exactly one cycle, in the result state
//   that follows the execute state, with rsp valid in that cycle. The
//   receiver cannot stall; the result is gone after that cycle.
//   Each item passes through latch, ring access and result steps, and no
//   new item is taken before the previous result. The ring is a single-port
//   memory with a registered read, and the result cycle waits on that read.
//   Reset: the queue comes up empty and in forward order. The ring itself is
//   not cleared and needs no clearing pass; only occupied slots are read.
//   Every request gives one result: value, status (ok, empty, position out
//   of range, full) and the occupancy after the request.
// ----------------------------------------------------------------------------
module bounded_deque_with_kth_from_end
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    cmd_t cmd;

    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    assign done = cmd.emit;

endmodule

@@ rtl/bdq_checker.sv @@
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on sequencing and result consistency of the deque.
// ----------------------------------------------------------------------------
module bdq_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    localparam int MW = ($clog2(DEPTH + 1) > OCC_W) ? $clog2(DEPTH + 1) : OCC_W;
    localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

    // every accepted item gives its result strobe once the execute state has passed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing two cycles after accept");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy && !$past(done)))
        else $error("result strobe outside a busy window or repeated");

    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STAT_OK) |-> (rsp.value_out == '0))
        else $error("nonzero value with a failing status");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_FULL) |-> (rsp.occupancy == DEPTH_OCC))
        else $error("full status while occupancy is below depth");

    logic unused_ok;
    assign unused_ok = ^{req, MW[0]};

endmodule

bind bounded_deque_with_kth_from_end bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);
